/* rtl/core/jtdm_pkg.sv */
// Shared types, constants and the arctangent table of the joystick tank drive mixer.
// Used by every module in rtl/core; depends on nothing else.
package jtdm_pkg;

  // CORDIC vectoring: 24 micro-rotations on values scaled by 2^24.
  localparam int CORDIC_BITS  = 24;
  localparam int CORDIC_STEPS = 24;
  localparam int CW           = 35;  // x and y width, signed
  localparam int ZW           = 34;  // angle accumulator width, signed
  localparam int SQRT_BITS    = 8;   // root of at most 20000 fits in 8 bits
  localparam int QUOT_BITS    = 7;   // mixing quotient is clamped to 101

  // Register map, by word index.
  typedef enum logic [1:0] {
    REG_MIX_MODE   = 2'd0,
    REG_MIN_ANGLE  = 2'd1,
    REG_MIN_EFFORT = 2'd2
  } reg_idx_t;

  // Per-axis efforts and flipper result of one sample.
  typedef struct packed {
    logic [7:0] s;        // speed effort, signed
    logic [7:0] d;        // direction effort, signed
    logic       dir_pos;  // centered direction offset above zero
    logic [7:0] fe;       // flipper effort, signed
  } axis_t;

  // State carried through the vectoring and square-root steps.
  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [ZW-1:0] z;
    logic [14:0]   n;     // s*s + d*d
    logic [7:0]    root;
    axis_t         ax;
  } vec_t;

  // Division request handed from the mixer to the divider.
  typedef struct packed {
    logic [13:0] num;
    logic [6:0]  den;
    logic        neg;
    logic        q_used;
    logic        q_left;
    logic [8:0]  l_fix;   // signed
    logic [8:0]  r_fix;   // signed
    logic [7:0]  fe;      // signed
  } divreq_t;

  // Divider stage state.
  typedef struct packed {
    logic [13:0]          rem;
    logic [QUOT_BITS-1:0] quo;
    divreq_t              req;
  } divst_t;

  // One finished result.
  typedef struct packed {
    logic [7:0]  le;
    logic [7:0]  re;
    logic [7:0]  fe;
    logic [15:0] lp;
    logic [15:0] rp;
    logic [15:0] fp;
  } res_t;

  // round(57.3 * atan(2^-i) * 2^24)
  function automatic logic [29:0] atan_entry(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'd755030332;
      5'd1:  v = 30'd445720432;
      5'd2:  v = 30'd235506435;
      5'd3:  v = 30'd119546744;
      5'd4:  v = 30'd60005354;
      5'd5:  v = 30'd30031929;
      5'd6:  v = 30'd15019629;
      5'd7:  v = 30'd7510273;
      5'd8:  v = 30'd3755194;
      5'd9:  v = 30'd1877604;
      5'd10: v = 30'd938803;
      5'd11: v = 30'd469402;
      5'd12: v = 30'd234701;
      5'd13: v = 30'd117350;
      5'd14: v = 30'd58675;
      5'd15: v = 30'd29338;
      5'd16: v = 30'd14669;
      5'd17: v = 30'd7334;
      5'd18: v = 30'd3667;
      5'd19: v = 30'd1834;
      5'd20: v = 30'd917;
      5'd21: v = 30'd458;
      5'd22: v = 30'd229;
      5'd23: v = 30'd115;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/core/jtdm_axis.sv */
// Front end of the mixer: centers both stick axes, scales, clamps and squares them,
// and prepares the vectoring state. Five register stages. Depends on jtdm_pkg.
module jtdm_axis import jtdm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       in_vld,
  input  logic [7:0] direction,
  input  logic [7:0] speed,
  input  logic [7:0] flipper_switch,
  input  logic [7:0] flipper_sense,
  output logic       out_vld,
  output vec_t       out
);

  // Stage 1 signals.
  logic [6:0]  md, ms;
  logic [25:0] pd, ps;
  logic [7:0]  vd_raw, vs_raw;
  logic [7:0]  fe_c;
  logic        v1;
  logic [6:0]  v1_d, v1_s;
  logic        n1_d, n1_s, dp1;
  logic [7:0]  fe1;
  // Stage 2 signals.
  logic        v2;
  logic [17:0] n2_d, n2_s;
  logic        n2_dn, n2_sn, dp2;
  logic [7:0]  fe2;
  // Stage 3 signals.
  logic [36:0] qd_p, qs_p;
  logic        v3;
  logic [6:0]  q3_d, q3_s;
  logic [17:0] n3_d, n3_s;
  logic        n3_dn, n3_sn, dp3;
  logic [7:0]  fe3;
  // Stage 4 signals.
  logic [17:0] rd, rs;
  logic [6:0]  ed, es;
  logic        v4;
  logic [6:0]  e4_d, e4_s;
  logic        n4_dn, n4_sn, dp4;
  logic [7:0]  fe4;
  // Stage 5 signals.
  vec_t        init;

  // Center the axes: magnitude of the offset from 127.5 and its sign.
  assign md = direction[7] ? direction[6:0] : ~direction[6:0];
  assign ms = speed[7] ? speed[6:0] : ~speed[6:0];
  // Scale by 1.4: floor(mag * 7 / 5) through a reciprocal of 5.
  assign pd = (26'(md) * 26'd7) * 26'd52429;
  assign ps = (26'(ms) * 26'd7) * 26'd52429;
  assign vd_raw = pd[25:18];
  assign vs_raw = ps[25:18];

  // Flipper effort only when the switch byte is exactly one.
  always_comb begin
    fe_c = 8'sd0;
    if (flipper_switch == 8'd1) begin
      if (flipper_sense == 8'd1) begin
        fe_c = -8'sd100;
      end else if (flipper_sense == 8'd0) begin
        fe_c = 8'sd100;
      end
    end
  end

  // Stage 1: clamped scaled magnitudes.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_vld;
    end
    if (en) begin
      v1_d <= (vd_raw > 8'd127) ? 7'd127 : vd_raw[6:0];
      v1_s <= (vs_raw > 8'd127) ? 7'd127 : vs_raw[6:0];
      n1_d <= direction[7];
      n1_s <= ~speed[7];
      dp1  <= ~direction[7] && (md != 7'd0);
      fe1  <= fe_c;
    end
  end

  // Stage 2: sixteen times the square.
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      n2_d  <= {14'(v1_d) * 14'(v1_d), 4'b0000};
      n2_s  <= {14'(v1_s) * 14'(v1_s), 4'b0000};
      n2_dn <= n1_d;
      n2_sn <= n1_s;
      dp2   <= dp1;
      fe2   <= fe1;
    end
  end

  // Stage 3: quotient estimate by the reciprocal of 2601, low by at most one.
  assign qd_p = 37'(n2_d) * 37'd412818;
  assign qs_p = 37'(n2_s) * 37'd412818;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      q3_d  <= qd_p[36:30];
      q3_s  <= qs_p[36:30];
      n3_d  <= n2_d;
      n3_s  <= n2_s;
      n3_dn <= n2_dn;
      n3_sn <= n2_sn;
      dp3   <= dp2;
      fe3   <= fe2;
    end
  end

  // Stage 4: correct the estimate with one compare.
  assign rd = n3_d - 18'(q3_d) * 18'd2601;
  assign rs = n3_s - 18'(q3_s) * 18'd2601;
  assign ed = (rd >= 18'd2601) ? q3_d + 7'd1 : q3_d;
  assign es = (rs >= 18'd2601) ? q3_s + 7'd1 : q3_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
    if (en) begin
      e4_d  <= ed;
      e4_s  <= es;
      n4_dn <= n3_dn;
      n4_sn <= n3_sn;
      dp4   <= dp3;
      fe4   <= fe3;
    end
  end

  // Stage 5: signed efforts, vectoring start values and the sum of squares.
  always_comb begin
    init.x          = CW'(e4_d) << CORDIC_BITS;
    init.y          = CW'(e4_s) << CORDIC_BITS;
    init.z          = '0;
    init.n          = 15'(e4_d) * 15'(e4_d) + 15'(e4_s) * 15'(e4_s);
    init.root       = '0;
    init.ax.d       = n4_dn ? -{1'b0, e4_d} : {1'b0, e4_d};
    init.ax.s       = n4_sn ? -{1'b0, e4_s} : {1'b0, e4_s};
    init.ax.dir_pos = dp4;
    init.ax.fe      = fe4;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= v4;
    end
    if (en) begin
      out <= init;
    end
  end

endmodule

/* rtl/core/jtdm_vec_step.sv */
// One pipelined CORDIC vectoring micro-rotation, plus one bit of the integer
// square root in the first steps. Depends on jtdm_pkg.
module jtdm_vec_step import jtdm_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_vld,
  input  vec_t in,
  output logic out_vld,
  output vec_t out
);

  localparam logic signed [ZW-1:0] ANG = signed'(ZW'(atan_entry(5'(STEP))));

  logic signed [CW-1:0] xs, ys, xsh, ysh;
  logic signed [ZW-1:0] zs;
  vec_t                 nxt;

  // Greedy root bit: keep it when its square still fits.
  function automatic logic [7:0] sq_bit(input logic [7:0] root, input logic [14:0] n);
    logic [7:0]  trial;
    logic [15:0] sq;
    trial = root | (8'd1 << (SQRT_BITS - 1 - STEP));
    sq    = 16'(trial) * 16'(trial);
    return (sq <= 16'(n)) ? trial : root;
  endfunction

  assign xs  = signed'(in.x);
  assign ys  = signed'(in.y);
  assign zs  = signed'(in.z);
  assign xsh = xs >>> STEP;
  assign ysh = ys >>> STEP;

  // Rotate toward the x axis and accumulate the angle.
  always_comb begin
    nxt = in;
    if (ys > 0) begin
      nxt.x = xs + ysh;
      nxt.y = ys - xsh;
      nxt.z = zs + ANG;
    end else begin
      nxt.x = xs - ysh;
      nxt.y = ys + xsh;
      nxt.z = zs - ANG;
    end
    if (STEP < SQRT_BITS) begin
      nxt.root = sq_bit(in.root, in.n);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
    if (en) begin
      out <= nxt;
    end
  end

endmodule

/* rtl/core/jtdm_mix.sv */
// Angle finish and effort mixing: forms the signed mixing product and turns it
// into a division request. Four register stages. Depends on jtdm_pkg.
module jtdm_mix import jtdm_pkg::*; #(
  parameter int FRAC = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       mix_mode,
  input  logic [6:0] min_angle_deg,
  input  logic [8:0] min_effort_q8,
  input  logic       in_vld,
  input  vec_t       in,
  output logic       out_vld,
  output divreq_t    out
);

  localparam int AW = FRAC + 9;
  localparam int TW = FRAC + 20;
  localparam int XW = TW + 9;
  localparam logic signed [AW-1:0] ANG90 = AW'(90 * (2 ** FRAC));
  localparam logic signed [AW-1:0] ANG20 = AW'(20 * (2 ** FRAC));
  localparam logic signed [TW-1:0] Q45   = TW'(45 * (2 ** FRAC));

  // Stage 1 signals.
  logic [FRAC+7:0]        amag;
  logic signed [AW-1:0]   ang_c;
  logic signed [7:0]      s_c, d_c;
  logic                   v1;
  logic signed [AW-1:0]   ang1;
  logic [7:0]             m1;
  logic                   sp1, sn1, dn1, dp1;
  logic [7:0]             fe1;
  // Stage 2 signals.
  logic [6:0]             ma, span;
  logic [8:0]             ef;
  logic signed [TW-1:0]   a_ext, ma_one, w, diff, prod1, prod2, t_c;
  logic [15:0]            es;
  logic                   band, qu_c, ql_c;
  logic signed [8:0]      mpos, lf_c, rf_c;
  logic                   v2, mode2;
  logic signed [TW-1:0]   t2;
  logic [6:0]             den2;
  logic                   qu2, ql2;
  logic [8:0]             lf2, rf2;
  logic [7:0]             m2, fe2;
  // Stage 3 signals.
  logic                   v3, mode3;
  logic signed [XW-1:0]   x3;
  logic [6:0]             den3;
  logic                   qu3, ql3;
  logic [8:0]             lf3, rf3;
  logic [7:0]             fe3;
  // Stage 4 signals.
  logic [XW-1:0]          absx, nsh;
  logic [13:0]            lim;
  divreq_t                req;

  // Angle in fixed point: truncate the accumulator, then apply the quadrant sign.
  assign amag = in.z[ZW-1] ? '0 : in.z[CORDIC_BITS-FRAC +: FRAC+8];
  assign s_c  = signed'(in.ax.s);
  assign d_c  = signed'(in.ax.d);

  always_comb begin
    if (d_c == 8'sd0) begin
      ang_c = (s_c > 8'sd0) ? ANG90 : -ANG90;
    end else if (s_c == 8'sd0) begin
      ang_c = '0;
    end else if (s_c[7] != d_c[7]) begin
      ang_c = -signed'(AW'(amag));
    end else begin
      ang_c = signed'(AW'(amag));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_vld;
    end
    if (en) begin
      ang1 <= ang_c;
      m1   <= in.root;
      sp1  <= s_c > 8'sd0;
      sn1  <= s_c[7];
      dn1  <= d_c[7];
      dp1  <= in.ax.dir_pos;
      fe1  <= in.ax.fe;
    end
  end

  // Stage 2: choose the mixing rule and form its factor.
  assign ma     = (min_angle_deg > 7'd89) ? 7'd89 : min_angle_deg;
  assign ef     = (min_effort_q8 > 9'd256) ? 9'd256 : min_effort_q8;
  assign span   = 7'd90 - ma;
  assign ma_one = signed'(TW'(ma) << FRAC);
  assign w      = signed'(TW'(10'd256 - 10'(ef)));
  assign es     = 16'(ef) * 16'(span);
  assign prod2  = signed'(TW'(es) << FRAC);
  assign band   = (ang1 > -ANG20) && (ang1 < ANG20);
  assign mpos   = signed'({1'b0, m1});
  assign diff   = a_ext - ma_one;
  assign prod1  = diff * w;

  always_comb begin
    a_ext = TW'(ang1);
    t_c   = '0;
    qu_c  = 1'b0;
    ql_c  = 1'b0;
    lf_c  = mpos;
    rf_c  = mpos;
    if (!mix_mode) begin
      if (band) begin
        lf_c = dp1 ? mpos : -mpos;
        rf_c = dp1 ? -mpos : mpos;
      end else if (sp1) begin
        qu_c = 1'b1;
        if (!dn1) begin
          lf_c = mpos;
        end else begin
          a_ext = -TW'(ang1);
          ql_c  = 1'b1;
          rf_c  = mpos;
        end
        t_c = prod1 + prod2;
      end else begin
        lf_c = -mpos;
        rf_c = -mpos;
      end
    end else begin
      qu_c = 1'b1;
      if (!sn1 && !dn1) begin
        lf_c = mpos;
        t_c  = TW'(ang1) - Q45;
      end else if (!sn1) begin
        ql_c = 1'b1;
        rf_c = mpos;
        t_c  = -(TW'(ang1) + Q45);
      end else if (!dn1) begin
        ql_c = 1'b1;
        rf_c = -mpos;
        t_c  = TW'(ang1) + Q45;
      end else begin
        lf_c = -mpos;
        t_c  = Q45 - TW'(ang1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      mode2 <= mix_mode;
      t2    <= t_c;
      den2  <= mix_mode ? 7'd45 : span;
      qu2   <= qu_c;
      ql2   <= ql_c;
      lf2   <= lf_c;
      rf2   <= rf_c;
      m2    <= m1;
      fe2   <= fe1;
    end
  end

  // Stage 3: multiply by the magnitude.
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      mode3 <= mode2;
      x3    <= XW'(signed'({1'b0, m2})) * XW'(t2);
      den3  <= den2;
      qu3   <= qu2;
      ql3   <= ql2;
      lf3   <= lf2;
      rf3   <= rf2;
      fe3   <= fe2;
    end
  end

  // Stage 4: drop the scale bits toward zero and clamp so the quotient stays below 128.
  assign absx = x3[XW-1] ? XW'(-x3) : XW'(x3);
  assign nsh  = mode3 ? (absx >> FRAC) : (absx >> (FRAC + 8));
  assign lim  = 14'(16'(den3) * 16'd101);

  always_comb begin
    req.num    = (nsh > XW'(lim)) ? lim : nsh[13:0];
    req.den    = den3;
    req.neg    = x3[XW-1];
    req.q_used = qu3;
    req.q_left = ql3;
    req.l_fix  = lf3;
    req.r_fix  = rf3;
    req.fe     = fe3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= v3;
    end
    if (en) begin
      out <= req;
    end
  end

endmodule

/* rtl/core/jtdm_div.sv */
// Pipelined restoring divider for the mixing quotient, one quotient bit per stage.
// Depends on jtdm_pkg.
module jtdm_div import jtdm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  input  logic    in_vld,
  input  divreq_t in,
  output logic    out_vld,
  output divst_t  out
);

  logic   vld [QUOT_BITS];
  divst_t st  [QUOT_BITS];

  for (genvar k = 0; k < QUOT_BITS; k++) begin : g_stage
    localparam int B = QUOT_BITS - 1 - k;
    divst_t cur, nxt;
    logic   cur_vld;
    logic [13:0] sub;

    if (k == 0) begin : g_first
      always_comb begin
        cur.rem = in.num;
        cur.quo = '0;
        cur.req = in;
      end
      assign cur_vld = in_vld;
    end else begin : g_next
      assign cur     = st[k-1];
      assign cur_vld = vld[k-1];
    end

    // Subtract the shifted divisor when it fits.
    assign sub = 14'(cur.req.den) << B;
    always_comb begin
      nxt = cur;
      if (cur.rem >= sub) begin
        nxt.rem    = cur.rem - sub;
        nxt.quo[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= cur_vld;
      end
      if (en) begin
        st[k] <= nxt;
      end
    end
  end

  assign out_vld = vld[QUOT_BITS-1];
  assign out     = st[QUOT_BITS-1];

endmodule

/* rtl/core/joystick_tank_drive_mixer.sv */
// Top level of the joystick tank drive mixer: register port, pipeline and output skid.
// Depends on jtdm_pkg, jtdm_axis, jtdm_vec_step, jtdm_mix and jtdm_div.
//
//   port group  | handshake                  | payload
//   ------------+----------------------------+----------------------------------------------
//   sample      | sample_valid, sample_stall | direction, speed, flipper_switch, flipper_sense
//   result      | result_valid, result_stall | efforts and pulse compare values
//   register    | psel, penable, pwrite      | paddr, pwdata, prdata, pready
//
// A sample is taken every cycle while sample_stall is low; its result passes through
// 41 register stages: 5 axis, 24 vectoring, 4 mixing, 7 divider and the output register.
// Reset clears all valid bits and restores the registers; no pass over storage.
// A stalled result is held in the output register and the pipeline keeps moving
// into a spare register; sample_stall rises only once that spare is occupied.
module joystick_tank_drive_mixer import jtdm_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_stall,
  input  logic [7:0]        direction,
  input  logic [7:0]        speed,
  input  logic [7:0]        flipper_switch,
  input  logic [7:0]        flipper_sense,
  output logic              result_valid,
  input  logic              result_stall,
  output logic signed [7:0] left_effort,
  output logic signed [7:0] right_effort,
  output logic signed [7:0] flipper_effort,
  output logic [15:0]       left_pulse,
  output logic [15:0]       right_pulse,
  output logic [15:0]       flipper_pulse,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic       mix_mode;
  logic [6:0] min_angle_deg;
  logic [8:0] min_effort_q8;
  logic       en;
  logic       spare_vld;
  res_t       out_r, spare, res_c;
  logic       vv [CORDIC_STEPS+1];
  vec_t       vs [CORDIC_STEPS+1];
  logic       mix_vld, div_vld;
  divreq_t    mix_req;
  divst_t     div_out;
  logic signed [8:0]  qs, lsel, rsel;
  logic signed [16:0] lp_c, rp_c, fp_c;

  assign pready = 1'b1;

  // Register writes on the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      mix_mode      <= 1'b0;
      min_angle_deg <= 7'd20;
      min_effort_q8 <= 9'd64;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx_t'(paddr[3:2]))
        REG_MIX_MODE:   mix_mode      <= pwdata[0];
        REG_MIN_ANGLE:  min_angle_deg <= pwdata[6:0];
        REG_MIN_EFFORT: min_effort_q8 <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_idx_t'(paddr[3:2]))
      REG_MIX_MODE:   prdata = 32'(mix_mode);
      REG_MIN_ANGLE:  prdata = 32'(min_angle_deg);
      REG_MIN_EFFORT: prdata = 32'(min_effort_q8);
      default:        prdata = '0;
    endcase
  end

  // The whole pipeline advances while the spare register is free.
  assign en           = ~spare_vld;
  assign sample_stall = spare_vld;

  jtdm_axis u_axis (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .in_vld         (sample_valid),
    .direction      (direction),
    .speed          (speed),
    .flipper_switch (flipper_switch),
    .flipper_sense  (flipper_sense),
    .out_vld        (vv[0]),
    .out            (vs[0])
  );

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_vec
    jtdm_vec_step #(.STEP(g)) u_step (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .in_vld  (vv[g]),
      .in      (vs[g]),
      .out_vld (vv[g+1]),
      .out     (vs[g+1])
    );
  end

  jtdm_mix #(.FRAC(ANGLE_FRAC_BITS)) u_mix (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .mix_mode      (mix_mode),
    .min_angle_deg (min_angle_deg),
    .min_effort_q8 (min_effort_q8),
    .in_vld        (vv[CORDIC_STEPS]),
    .in            (vs[CORDIC_STEPS]),
    .out_vld       (mix_vld),
    .out           (mix_req)
  );

  jtdm_div u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (mix_vld),
    .in      (mix_req),
    .out_vld (div_vld),
    .out     (div_out)
  );

  // Place the signed quotient, saturate and form the compare values.
  assign qs   = div_out.req.neg ? -signed'({2'b00, div_out.quo})
                                : signed'({2'b00, div_out.quo});
  assign lsel = (div_out.req.q_used && div_out.req.q_left) ? qs
                                                           : signed'(div_out.req.l_fix);
  assign rsel = (div_out.req.q_used && !div_out.req.q_left) ? qs
                                                            : signed'(div_out.req.r_fix);

  always_comb begin
    res_c.le = (lsel > 9'sd100) ? 8'sd100 : (lsel < -9'sd100) ? -8'sd100 : lsel[7:0];
    res_c.re = (rsel > 9'sd100) ? 8'sd100 : (rsel < -9'sd100) ? -8'sd100 : rsel[7:0];
    res_c.fe = div_out.req.fe;
  end

  assign lp_c = 17'sd37000 + 17'(signed'(res_c.le)) * 17'sd10;
  assign rp_c = 17'sd37000 - 17'(signed'(res_c.re)) * 17'sd10;
  assign fp_c = 17'sd37000 - 17'(signed'(res_c.fe)) * 17'sd10;

  // Output register with a spare behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      spare_vld    <= 1'b0;
    end else if (spare_vld) begin
      if (!result_stall) begin
        out_r     <= spare;
        spare_vld <= 1'b0;
      end
    end else if (div_vld) begin
      if (!result_valid || !result_stall) begin
        out_r        <= '{le: res_c.le, re: res_c.re, fe: res_c.fe,
                          lp: lp_c[15:0], rp: rp_c[15:0], fp: fp_c[15:0]};
        result_valid <= 1'b1;
      end else begin
        spare     <= '{le: res_c.le, re: res_c.re, fe: res_c.fe,
                       lp: lp_c[15:0], rp: rp_c[15:0], fp: fp_c[15:0]};
        spare_vld <= 1'b1;
      end
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  assign left_effort    = signed'(out_r.le);
  assign right_effort   = signed'(out_r.re);
  assign flipper_effort = signed'(out_r.fe);
  assign left_pulse     = out_r.lp;
  assign right_pulse    = out_r.rp;
  assign flipper_pulse  = out_r.fp;

`ifndef SYNTH
  // The spare register is only used behind a waiting result.
  a_spare_behind_out: assert property (@(posedge clk) disable iff (rst)
    spare_vld |-> result_valid)
    else $error("spare register holds a transaction with no result waiting");

  // A spare transaction moves out as soon as the result is taken.
  a_spare_drains: assert property (@(posedge clk) disable iff (rst)
    (spare_vld && !result_stall) |=> !spare_vld)
    else $error("spare register did not drain");

  // Efforts stay saturated.
  a_effort_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (left_effort <= 8'sd100 && left_effort >= -8'sd100 &&
                      right_effort <= 8'sd100 && right_effort >= -8'sd100))
    else $error("track effort out of range");

  // Flipper effort is full reverse, off or full forward.
  a_flipper_codes: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (flipper_effort == -8'sd100 || flipper_effort == 8'sd0 ||
                      flipper_effort == 8'sd100))
    else $error("flipper effort not a legal level");
`endif

endmodule

/* dv/joystick_tank_drive_mixer_checker.sv */
// Checker for the joystick tank drive mixer: predicts every result and compares it.
// Depends on jtdm_pkg for the register indexes and the result layout.
`timescale 1ns / 100ps

module joystick_tank_drive_mixer_checker import jtdm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  input  logic              sample_stall,
  input  logic [7:0]        direction,
  input  logic [7:0]        speed,
  input  logic [7:0]        flipper_switch,
  input  logic [7:0]        flipper_sense,
  input  logic              result_valid,
  input  logic              result_stall,
  input  logic signed [7:0] left_effort,
  input  logic signed [7:0] right_effort,
  input  logic signed [7:0] flipper_effort,
  input  logic [15:0]       left_pulse,
  input  logic [15:0]       right_pulse,
  input  logic [15:0]       flipper_pulse,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  output int                fail_count,
  output int                outstanding
);

  localparam longint ANG_ONE = 256;

  // Arctangent steps in degrees, scaled by 2^24.
  localparam longint ATAN_STEP [24] = '{
    755030332, 445720432, 235506435, 119546744, 60005354, 30031929,
    15019629, 7510273, 3755194, 1877604, 938803, 469402,
    234701, 117350, 58675, 29338, 14669, 7334,
    3667, 1834, 917, 458, 229, 115
  };

  logic       mode_q;
  logic [6:0] min_angle_q;
  logic [8:0] min_effort_q;
  res_t       expected_q[$];

  // Centered axis offset to a squared, sign-preserving effort.
  function automatic int axis_to_effort(input int off);
    int v;
    int e;
    v = off * 14 / 10;
    if (v > 127) v = 127;
    if (v < -127) v = -127;
    e = (v * v * 400) / 65025;
    return (v > 0) ? e : -e;
  endfunction

  // Vectoring rotation: 57.3*atan(s/d) in Q8 degrees.
  function automatic longint vector_angle(input int s, input int d);
    longint x;
    longint y;
    longint z;
    longint nx;
    longint a;
    x = longint'(d < 0 ? -d : d) <<< 24;
    y = longint'(s < 0 ? -s : s) <<< 24;
    z = 0;
    if (s == 0) return 0;
    for (int i = 0; i < 24; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += ATAN_STEP[i];
      end else begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= ATAN_STEP[i];
      end
      x = nx;
    end
    if (z < 0) z = 0;
    a = z >>> 16;
    return ((s < 0) != (d < 0)) ? -a : a;
  endfunction

  function automatic longint floor_root(input longint n);
    longint r;
    r = 0;
    while ((r + 1) * (r + 1) <= n) r++;
    return r;
  endfunction

  function automatic int clamp100(input longint v);
    if (v > 100) return 100;
    if (v < -100) return -100;
    return int'(v);
  endfunction

  // Inner-wheel effort outside the turn band.
  function automatic longint inner_wheel(input longint m, input longint ang);
    longint ma;
    longint e;
    longint span;
    ma = (min_angle_q > 89) ? 89 : longint'(min_angle_q);
    e = (min_effort_q > 256) ? 256 : longint'(min_effort_q);
    span = (90 - ma) * ANG_ONE;
    return (m * (ang - ma * ANG_ONE) * (256 - e) + m * e * span) / (span * 256);
  endfunction

  function automatic res_t predict_drive(input logic [7:0] dir, input logic [7:0] spd,
                                         input logic [7:0] fon, input logic [7:0] fdir);
    int     doff;
    int     soff;
    int     d;
    int     s;
    int     le;
    int     re;
    int     fe;
    longint ang;
    longint m;
    longint l;
    longint r;
    longint q;
    res_t   res;
    doff = (dir <= 127) ? 127 - int'(dir) : 128 - int'(dir);
    soff = (spd >= 128) ? int'(spd) - 128 : int'(spd) - 127;
    d = axis_to_effort(doff);
    s = axis_to_effort(soff);
    if (d == 0) ang = (s > 0) ? 90 * ANG_ONE : -90 * ANG_ONE;
    else ang = vector_angle(s, d);
    m = floor_root(s * s + d * d);
    q = 45 * ANG_ONE;
    if (!mode_q) begin
      // Turn band spins in place; forward mixes, reverse runs both tracks back.
      if (ang > -20 * ANG_ONE && ang < 20 * ANG_ONE) begin
        l = (doff > 0) ? m : -m;
        r = -l;
      end else if (s > 0) begin
        if (d >= 0) begin
          l = m;
          r = inner_wheel(m, ang);
        end else begin
          r = m;
          l = inner_wheel(m, -ang);
        end
      end else begin
        l = -m;
        r = -m;
      end
    end else begin
      if (s >= 0) begin
        if (d >= 0) begin
          l = m;
          r = m * (ang - q) / q;
        end else begin
          r = m;
          l = -m * (ang + q) / q;
        end
      end else begin
        if (d >= 0) begin
          r = -m;
          l = m * (ang + q) / q;
        end else begin
          l = -m;
          r = m * (q - ang) / q;
        end
      end
    end
    le = clamp100(l);
    re = clamp100(r);
    fe = 0;
    if (fon == 8'd1) begin
      if (fdir == 8'd1) fe = -100;
      else if (fdir == 8'd0) fe = 100;
    end
    res.le = le[7:0];
    res.re = re[7:0];
    res.fe = fe[7:0];
    res.lp = 16'(37000 + 10 * le);
    res.rp = 16'(37000 - 10 * re);
    res.fp = 16'(37000 - 10 * fe);
    return res;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
    fail_count++;
  endtask

  // Register writes, accepted samples and accepted results, all seen at the edge.
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      mode_q <= 1'b0;
      min_angle_q <= 7'd20;
      min_effort_q <= 9'd64;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_MIX_MODE:   mode_q <= pwdata[0];
          REG_MIN_ANGLE:  min_angle_q <= pwdata[6:0];
          REG_MIN_EFFORT: min_effort_q <= pwdata[8:0];
          default: ;
        endcase
      end
      if (sample_valid && !sample_stall)
        expected_q.push_back(predict_drive(direction, speed, flipper_switch,
                                           flipper_sense));
      if (result_valid && !result_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected transaction", 1, 0);
        end else begin
          want = expected_q.pop_front();
          if (left_effort != want.le)
            report_mismatch("left_effort", left_effort, $signed(want.le));
          if (right_effort != want.re)
            report_mismatch("right_effort", right_effort, $signed(want.re));
          if (flipper_effort != want.fe)
            report_mismatch("flipper_effort", flipper_effort, $signed(want.fe));
          if (left_pulse != want.lp) report_mismatch("left_pulse", left_pulse, want.lp);
          if (right_pulse != want.rp) report_mismatch("right_pulse", right_pulse, want.rp);
          if (flipper_pulse != want.fp)
            report_mismatch("flipper_pulse", flipper_pulse, want.fp);
        end
      end
    end
    outstanding = expected_q.size();
  end

  initial fail_count = 0;

endmodule

/* dv/joystick_tank_drive_mixer_tb.sv */
// Top of the joystick tank drive mixer testbench: clock, reset, stimulus and verdict.
// Depends on jtdm_pkg, the mixer RTL and joystick_tank_drive_mixer_checker.
`timescale 1ns / 100ps

module joystick_tank_drive_mixer_tb import jtdm_pkg::*;;

  localparam int QUIET_CYCLES = 60;
  localparam int STALL_LIMIT  = 5000;
  localparam int CHUNK_ITEMS  = 183;
  localparam logic [1:0] SPARE_IDX = 2'd3;

  logic              clk;
  logic              rst;
  logic              sample_valid;
  logic              sample_stall;
  logic [7:0]        direction;
  logic [7:0]        speed;
  logic [7:0]        flipper_switch;
  logic [7:0]        flipper_sense;
  logic              result_valid;
  logic              result_stall;
  logic signed [7:0] left_effort;
  logic signed [7:0] right_effort;
  logic signed [7:0] flipper_effort;
  logic [15:0]       left_pulse;
  logic [15:0]       right_pulse;
  logic [15:0]       flipper_pulse;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [3:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  int   fail_count;
  int   outstanding;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   quiet_count;
  int   sent_count;
  int   config_count;
  logic sample_took;

  joystick_tank_drive_mixer dut (.*);

  joystick_tank_drive_mixer_checker chk (.*);

  // Clock: 8 ns period.
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Acceptance flag for the sender, and the watchdog on stalled progress.
  always @(posedge clk) begin
    sample_took <= sample_valid && !sample_stall;
    if (rst || (sample_valid && !sample_stall) || (result_valid && !result_stall))
      quiet_count <= 0;
    else
      quiet_count <= quiet_count + 1;
    if (quiet_count >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver stalls at random.
  always @(negedge clk) begin
    if (rst) result_stall <= 1'b0;
    else result_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic send_sample(input logic [7:0] d, input logic [7:0] s,
                             input logic [7:0] fon, input logic [7:0] fdir);
    if ($urandom_range(99) < send_idle_pct) begin
      sample_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    sample_valid = 1'b1;
    direction = d;
    speed = s;
    flipper_switch = fon;
    flipper_sense = fdir;
    do @(negedge clk); while (!sample_took);
    sent_count++;
  endtask

  // Waits until every result is back and the pipeline has drained.
  task automatic drain;
    sample_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    config_count++;
  endtask

  task automatic random_sample;
    logic [7:0] d;
    logic [7:0] s;
    logic [7:0] fon;
    logic [7:0] fdir;
    // Bias toward the stick center, where dead zone and axis edge cases live.
    d = ($urandom_range(9) < 2) ? 8'($urandom_range(118, 137)) : 8'($urandom_range(255));
    s = ($urandom_range(9) < 2) ? 8'($urandom_range(118, 137)) : 8'($urandom_range(255));
    fon = ($urandom_range(9) < 5) ? 8'd1 : 8'($urandom_range(255));
    fdir = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(1));
    send_sample(d, s, fon, fdir);
  endtask

  initial begin
    int angle_set [9] = '{0, 89, 127, 45, 20, 1, 60, 89, 0};
    int effort_set [9] = '{256, 0, 511, 64, 128, 256, 0, 300, 17};
    int k;
    rst = 1'b1;
    sample_valid = 1'b0;
    direction = 8'd0;
    speed = 8'd0;
    flipper_switch = 8'd0;
    flipper_sense = 8'd0;
    result_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = 4'd0;
    pwdata = 32'd0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    sent_count = 0;
    config_count = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: reset settings, axis extremes, center, flipper codes.
    send_sample(8'd0, 8'd0, 8'd1, 8'd1);
    send_sample(8'd255, 8'd255, 8'd1, 8'd0);
    send_sample(8'd127, 8'd127, 8'd1, 8'd2);
    send_sample(8'd128, 8'd128, 8'd0, 8'd0);
    send_sample(8'd127, 8'd255, 8'd255, 8'd255);
    send_sample(8'd128, 8'd0, 8'd1, 8'd255);
    send_sample(8'd0, 8'd128, 8'd2, 8'd1);
    send_sample(8'd255, 8'd127, 8'd1, 8'd1);
    send_sample(8'd0, 8'd255, 8'd1, 8'd0);
    send_sample(8'd255, 8'd0, 8'd1, 8'd0);
    send_sample(8'd60, 8'd200, 8'd1, 8'd1);
    send_sample(8'd200, 8'd200, 8'd1, 8'd1);
    drain();
    // Same corners in linear mode, plus a write to an unused register.
    reg_write(REG_MIX_MODE, 32'hFFFF_FFFF);
    reg_write(SPARE_IDX, 32'd1);
    send_sample(8'd0, 8'd0, 8'd1, 8'd1);
    send_sample(8'd255, 8'd255, 8'd1, 8'd0);
    send_sample(8'd127, 8'd127, 8'd0, 8'd0);
    send_sample(8'd0, 8'd255, 8'd1, 8'd0);
    send_sample(8'd255, 8'd0, 8'd1, 8'd0);
    send_sample(8'd128, 8'd255, 8'd1, 8'd0);
    send_sample(8'd127, 8'd0, 8'd1, 8'd0);
    send_sample(8'd60, 8'd60, 8'd1, 8'd0);

    // Random: three idling phases, three register settings in each.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 29 : (ph == 1) ? 61 : 0;
      recv_stall_pct = (ph == 0) ? 61 : (ph == 1) ? 29 : 0;
      for (int c = 0; c < 3; c++) begin
        k = ph * 3 + c;
        drain();
        reg_write(REG_MIX_MODE, 32'(k % 2));
        reg_write(REG_MIN_ANGLE, 32'(angle_set[k]));
        reg_write(REG_MIN_EFFORT, 32'(effort_set[k]));
        repeat (CHUNK_ITEMS) random_sample();
      end
    end
    drain();

    $display("Run covered %0d samples over %0d register writes,", sent_count, config_count);
    $display("both mixing modes, angle and effort limits, and three idling phases.");
    if (fail_count == 0 && outstanding == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/jtdm_pkg.sv
rtl/core/jtdm_axis.sv
rtl/core/jtdm_vec_step.sv
rtl/core/jtdm_mix.sv
rtl/core/jtdm_div.sv
rtl/core/joystick_tank_drive_mixer.sv
dv/joystick_tank_drive_mixer_checker.sv
dv/joystick_tank_drive_mixer_tb.sv
